// ----- rtl/pid_conditional_integration_assert.svh -----
// Concurrent assertion helpers used by the RTL.
`ifndef PID_CONDITIONAL_INTEGRATION_ASSERT_SVH
`define PID_CONDITIONAL_INTEGRATION_ASSERT_SVH

// Same-cycle implication.
`define PCI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pci assertion failed");

// Next-cycle implication.
`define PCI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pci assertion failed");

`endif

// ----- rtl/pci_pkg.sv -----
`default_nettype none
package pci_pkg;

  localparam int unsigned NumRegs = 5;
  localparam int unsigned IdxW    = 3;

  localparam logic [IdxW-1:0] REG_KP = 3'd0;
  localparam logic [IdxW-1:0] REG_KI = 3'd1;
  localparam logic [IdxW-1:0] REG_KD = 3'd2;
  localparam logic [IdxW-1:0] REG_LO = 3'd3;
  localparam logic [IdxW-1:0] REG_HI = 3'd4;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic signed [47:0] Q48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Q48_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDT,
    ST_DIV,
    ST_MP,
    ST_MD,
    ST_MI,
    ST_MO,
    ST_CHK,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    K_STEP,
    K_CLEAR,
    K_NULL
  } kind_e;

  // floor(product / 2^16) saturated to signed 48 bits
  function automatic logic signed [47:0] sat_term(input logic [79:0] p);
    logic uni;
    uni = (&p[79:63]) | ~(|p[79:63]);
    if (uni) return $signed(p[63:16]);
    return p[79] ? Q48_MIN : Q48_MAX;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pci_if.sv -----
`default_nettype none
interface pci_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] setpoint;
  logic [31:0] measured;
  logic [23:0] time_step;
  modport source (output valid, operation, setpoint, measured, time_step, input ready);
  modport sink (input valid, operation, setpoint, measured, time_step, output ready);
endinterface

interface pci_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive;
  logic        clamped;
  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

interface pci_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pid_conditional_integration.sv -----
// Sequence: a clear or zero time step goes from ST_IDLE straight to ST_OUT; a step
//   runs the multiplies, and the derivative divide only when history is present.
// Throughput: one transaction at a time, set by the bit-serial 32-step multiplier
//   (used five times) and the 58-step restoring divider for the derivative.
// Reset (rst_ni low, async): gains 0, limits full range, integral, last error
//   and history cleared, no result pending.
`default_nettype none
`include "pid_conditional_integration_assert.svh"
module pid_conditional_integration
  import pci_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pci_cfg_if.sink    cfg_i,
  pci_req_if.sink    req_i,
  pci_rsp_if.source  rsp_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic [5:0] cnt_q, cnt_d;

  logic signed [31:0] kp_q, ki_q, kd_q, lo_q, hi_q;
  logic signed [47:0] integ_q, integ_d;
  logic signed [32:0] last_q, last_d;
  logic hist_q, hist_d;

  logic signed [32:0] err_q, err_d;
  logic [23:0] dt_q, dt_d;
  logic signed [47:0] cand_q, cand_d, deriv_q, deriv_d;
  logic signed [47:0] tic_q, tic_d, tio_q, tio_d;
  logic signed [49:0] pd_q, pd_d, yfin_q, yfin_d;
  logic commit_q, commit_d;

  logic [47:0] ma_q, ma_d;
  logic [31:0] mc_q, mc_d;
  logic [79:0] prod_q, prod_d;
  logic [24:0] rem_q, rem_d;
  logic [57:0] dvd_q, dvd_d;
  logic dneg_q, dneg_d;

  logic ov_q, ov_d;
  logic [31:0] drive_q, drive_d;
  logic clamped_q, clamped_d;

  // multiplier step: add (or subtract on the sign bit) then shift right
  logic signed [48:0] a_ext, addend, msum;
  logic [79:0] mul_next;
  logic signed [47:0] term;
  logic mul_last;

  always_comb begin
    mul_last = (cnt_q == 6'd31);
    a_ext    = $signed({ma_q[47], ma_q});
    addend   = mc_q[0] ? (mul_last ? -a_ext : a_ext) : '0;
    msum     = $signed({prod_q[79], prod_q[79:32]}) + addend;
    mul_next = {msum, prod_q[31:1]};
    term     = sat_term(mul_next);
  end

  // divider step
  logic [24:0] rtry;
  logic [24:0] rsub;
  always_comb begin
    rtry = {rem_q[23:0], dvd_q[57]};
    rsub = rtry - {1'b0, dt_q};
  end

  logic signed [31:0] lo_e, hi_e;
  always_comb begin
    if (lo_q > hi_q) begin
      lo_e = hi_q;
      hi_e = lo_q;
    end else begin
      lo_e = lo_q;
      hi_e = hi_q;
    end
  end

  logic signed [32:0] err_new;
  logic signed [33:0] diff;
  logic [33:0] dmag;
  logic [32:0] inc;
  logic signed [48:0] csum;
  logic signed [49:0] y1, y2, lo50, hi50;
  logic [57:0] q;
  logic [47:0] qneg;

  always_comb begin
    err_new = $signed({req_i.setpoint[31], req_i.setpoint})
            - $signed({req_i.measured[31], req_i.measured});
    diff = $signed({err_q[32], err_q}) - $signed({last_q[32], last_q});
    dmag = diff[33] ? 34'(-diff) : 34'(diff);
    inc  = mul_next[56:24];
    csum = $signed({integ_q[47], integ_q}) + $signed({{16{inc[32]}}, inc});
    y1   = pd_q + $signed({{2{tic_q[47]}}, tic_q});
    y2   = pd_q + $signed({{2{tio_q[47]}}, tio_q});
    lo50 = $signed({{18{lo_e[31]}}, lo_e});
    hi50 = $signed({{18{hi_e[31]}}, hi_e});
    q    = {dvd_q[56:0], ~rsub[24]};
    qneg = 48'(-q[47:0]);
  end

  always_comb begin
    state_d = state_q; kind_d = kind_q; cnt_d = cnt_q;
    integ_d = integ_q; last_d = last_q; hist_d = hist_q;
    err_d = err_q; dt_d = dt_q; cand_d = cand_q; deriv_d = deriv_q;
    tic_d = tic_q; tio_d = tio_q; pd_d = pd_q; yfin_d = yfin_q; commit_d = commit_q;
    ma_d = ma_q; mc_d = mc_q; prod_d = prod_q;
    rem_d = rem_q; dvd_d = dvd_q; dneg_d = dneg_q;
    ov_d = ov_q & ~rsp_o.ready;
    drive_d = drive_q; clamped_d = clamped_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          err_d = err_new;
          dt_d  = req_i.time_step;
          if (req_i.operation == OP_CLEAR) begin
            kind_d  = K_CLEAR;
            state_d = ST_OUT;
          end else if (req_i.time_step == '0) begin
            kind_d  = K_NULL;
            state_d = ST_OUT;
          end else begin
            kind_d  = K_STEP;
            ma_d    = 48'(err_new);
            mc_d    = {8'b0, req_i.time_step};
            prod_d  = '0;
            cnt_d   = '0;
            state_d = ST_MDT;
          end
        end
      end
      ST_MDT: begin
        prod_d = mul_next; mc_d = mc_q >> 1; cnt_d = cnt_q + 6'd1;
        if (mul_last) begin
          if (csum[48] != csum[47]) cand_d = csum[48] ? Q48_MIN : Q48_MAX;
          else cand_d = csum[47:0];
          cnt_d = '0;
          if (hist_q) begin
            rem_d   = '0;
            dvd_d   = {dmag, 24'b0};
            dneg_d  = diff[33];
            state_d = ST_DIV;
          end else begin
            deriv_d = '0;
            ma_d    = 48'(err_q);
            mc_d    = kp_q;
            prod_d  = '0;
            state_d = ST_MP;
          end
        end
      end
      ST_DIV: begin
        rem_d = rsub[24] ? rtry : rsub;
        dvd_d = q;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd57) begin
          if (dneg_q) begin
            if ((|q[57:48]) || (q[47] && (|q[46:0]))) deriv_d = Q48_MIN;
            else deriv_d = qneg;
          end else begin
            if (|q[57:47]) deriv_d = Q48_MAX;
            else deriv_d = q[47:0];
          end
          cnt_d   = '0;
          ma_d    = 48'(err_q);
          mc_d    = kp_q;
          prod_d  = '0;
          state_d = ST_MP;
        end
      end
      ST_MP, ST_MD, ST_MI, ST_MO: begin
        prod_d = mul_next; mc_d = mc_q >> 1; cnt_d = cnt_q + 6'd1;
        if (mul_last) begin
          cnt_d  = '0;
          prod_d = '0;
          if (state_q == ST_MP) begin
            pd_d = 50'(term);
            ma_d = deriv_q; mc_d = kd_q; state_d = ST_MD;
          end else if (state_q == ST_MD) begin
            pd_d = pd_q + 50'(term);
            ma_d = cand_q; mc_d = ki_q; state_d = ST_MI;
          end else if (state_q == ST_MI) begin
            tic_d = term;
            ma_d = integ_q; mc_d = ki_q; state_d = ST_MO;
          end else begin
            tio_d = term;
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        commit_d = ((y1 <= hi50) && (y1 >= lo50)) || ((y1 > hi50) && err_q[32])
                || ((y1 < lo50) && !err_q[32] && (err_q != '0));
        yfin_d = commit_d ? y1 : y2;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d = 1'b1;
          drive_d = '0;
          clamped_d = 1'b0;
          state_d = ST_IDLE;
          if (kind_q == K_CLEAR) begin
            integ_d = '0; last_d = '0; hist_d = 1'b0;
          end else if (kind_q == K_STEP) begin
            if (commit_q) integ_d = cand_q;
            last_d = err_q;
            hist_d = 1'b1;
            if (yfin_q > hi50) begin
              drive_d = hi_e; clamped_d = 1'b1;
            end else if (yfin_q < lo50) begin
              drive_d = lo_e; clamped_d = 1'b1;
            end else begin
              drive_d = yfin_q[31:0];
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= K_NULL;
      cnt_q   <= '0;
      integ_q <= '0;
      last_q  <= '0;
      hist_q  <= 1'b0;
      ov_q    <= 1'b0;
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      lo_q    <= 32'sh8000_0000;
      hi_q    <= 32'sh7FFF_FFFF;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      integ_q <= integ_d;
      last_q  <= last_d;
      hist_q  <= hist_d;
      ov_q    <= ov_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_KP:  kp_q <= cfg_i.data;
          REG_KI:  ki_q <= cfg_i.data;
          REG_KD:  kd_q <= cfg_i.data;
          REG_LO:  lo_q <= cfg_i.data;
          REG_HI:  hi_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d; dt_q <= dt_d; cand_q <= cand_d; deriv_q <= deriv_d;
    tic_q <= tic_d; tio_q <= tio_d; pd_q <= pd_d; yfin_q <= yfin_d;
    commit_q <= commit_d;
    ma_q <= ma_d; mc_q <= mc_d; prod_q <= prod_d;
    rem_q <= rem_d; dvd_q <= dvd_d; dneg_q <= dneg_d;
    drive_q <= drive_d; clamped_q <= clamped_d;
  end

  assign cfg_i.ready   = 1'b1;
  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = ov_q;
  assign rsp_o.drive   = drive_q;
  assign rsp_o.clamped = clamped_q;

  `PCI_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, req_i.valid && req_i.ready,
    state_q != ST_IDLE)
  `PCI_ASSERT_IMP(a_mul_count, clk_i, rst_ni,
    state_q == ST_MP || state_q == ST_MD || state_q == ST_MI || state_q == ST_MO,
    cnt_q <= 6'd31)
  `PCI_ASSERT_NXT(a_clear_state, clk_i, rst_ni,
    state_q == ST_OUT && kind_q == K_CLEAR && (!ov_q || rsp_o.ready),
    integ_q == '0 && !hist_q && last_q == '0)
  `PCI_ASSERT_IMP(a_clamp_limit, clk_i, rst_ni, ov_q && clamped_q,
    $signed(drive_q) == lo_e || $signed(drive_q) == hi_e)

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import pci_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 600;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } drive_t;

  logic clk;
  logic rst_n;

  pci_cfg_if cfg();
  pci_req_if req();
  pci_rsp_if rsp();

  pid_conditional_integration uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .req_i (req),
    .rsp_o (rsp)
  );

  // controller state as the block should hold it
  logic [31:0] gain_p, gain_i, gain_d, lim_lo, lim_hi;
  longint      integ_acc;
  longint      prev_err;
  bit          primed;

  drive_t      expected_q[$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  bit          rsp_hold;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat48(longint a);
    if (a > longint'(Q48_MAX)) return longint'(Q48_MAX);
    if (a < longint'(Q48_MIN)) return longint'(Q48_MIN);
    return a;
  endfunction

  // floor(g * a / 2^16), split so the product fits in 64 bits
  function automatic longint gain_term(logic [31:0] g, longint a);
    longint gs;
    longint hi;
    longint lo;
    gs = longint'($signed(g));
    hi = a >>> 16;
    lo = a - hi * 65536;
    return sat48(hi * gs + ((lo * gs) >>> 16));
  endfunction

  function automatic longint loop_output(longint e, longint integ, longint deriv);
    return gain_term(gain_p, e) + gain_term(gain_i, integ) + gain_term(gain_d, deriv);
  endfunction

  function automatic drive_t pid_predict(logic op, logic [31:0] sp, logic [31:0] ms,
                                         logic [23:0] dt);
    drive_t r;
    longint e, cand, deriv, lo, hi, y;
    r = '0;
    deriv = 0;
    if (op == OP_CLEAR) begin
      integ_acc = 0;
      prev_err = 0;
      primed = 1'b0;
      return r;
    end
    if (dt == 24'd0) return r;
    e = longint'($signed(sp)) - longint'($signed(ms));
    cand = sat48(integ_acc + ((e * longint'(dt)) >>> 24));
    if (primed) deriv = sat48(((e - prev_err) * 16777216) / longint'(dt));
    lo = longint'($signed(lim_lo));
    hi = longint'($signed(lim_hi));
    if (lo > hi) begin
      y = lo;
      lo = hi;
      hi = y;
    end
    y = loop_output(e, cand, deriv);
    if ((y <= hi && y >= lo) || (y > hi && e < 0) || (y < lo && e > 0)) integ_acc = cand;
    y = loop_output(e, integ_acc, deriv);
    prev_err = e;
    primed = 1'b1;
    if (y > hi) begin
      y = hi;
      r.clamped = 1'b1;
    end else if (y < lo) begin
      y = lo;
      r.clamped = 1'b1;
    end
    r.drive = y[31:0];
    return r;
  endfunction

  // receiver: random stalls, plus an optional long hold-off
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = !rsp_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    drive_t exp_r;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result drive=%h clamped=%b",
                                       rsp.drive, rsp.clamped);
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp.drive !== exp_r.drive || rsp.clamped !== exp_r.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: drive exp %h got %h, clamped exp %b got %b",
                     exp_r.drive, rsp.drive, exp_r.clamped, rsp.clamped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL pid_conditional_integration");
      $finish;
    end
  end

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wait_drain();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_KP: gain_p = val;
      REG_KI: gain_i = val;
      REG_KD: gain_d = val;
      REG_LO: lim_lo = val;
      REG_HI: lim_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_cmd(logic op, logic [31:0] sp, logic [31:0] ms, logic [23:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.operation = op;
    req.setpoint = sp;
    req.measured = ms;
    req.time_step = dt;
    do @(posedge clk); while (!req.ready);
    expected_q.push_back(pid_predict(op, sp, ms, dt));
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic pause_sender();
    req.valid = 1'b0;
    wait_drain();
  endtask

  task automatic send_random();
    logic        op;
    logic [31:0] sp, ms, base;
    logic [23:0] dt;
    op = ($urandom_range(99) < 5) ? OP_CLEAR : OP_STEP;
    if ($urandom_range(1)) begin
      sp = $urandom();
      ms = $urandom();
    end else begin
      // nearby values keep the loop out of saturation
      base = $urandom_range(32'h0040_0000) - 32'h0020_0000;
      sp = base + $urandom_range(32'h0008_0000) - 32'h0004_0000;
      ms = base;
    end
    case ($urandom_range(9))
      0: dt = 24'd0;
      1: dt = 24'hFF_FFFF;
      2, 3: dt = 24'($urandom());
      default: dt = 24'($urandom_range(24'h04_0000, 1));
    endcase
    send_cmd(op, sp, ms, dt);
  endtask

  task automatic random_gains();
    logic [31:0] lo, hi;
    case ($urandom_range(3))
      0: begin
        write_reg(REG_KP, $urandom());
        write_reg(REG_KI, $urandom());
        write_reg(REG_KD, $urandom());
      end
      default: begin
        write_reg(REG_KP, $urandom_range(32'h0004_0000) - 32'h0002_0000);
        write_reg(REG_KI, $urandom_range(32'h0004_0000) - 32'h0002_0000);
        write_reg(REG_KD, $urandom_range(32'h0000_1000) - 32'h0000_0800);
      end
    endcase
    case ($urandom_range(3))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = $urandom();
        hi = $urandom();
      end
      default: begin
        lo = -$urandom_range(32'h0040_0000);
        hi = $urandom_range(32'h0040_0000);
      end
    endcase
    write_reg(REG_LO, lo);
    write_reg(REG_HI, hi);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // reset gains: drive zero everywhere
    send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_cmd(OP_CLEAR, $urandom(), $urandom(), 24'($urandom()));
    write_reg(REG_KP, 32'h0001_0000);
    write_reg(REG_KI, 32'h0000_8000);
    write_reg(REG_KD, 32'h0000_0100);
    write_reg(REG_LO, 32'hFFF0_0000);
    write_reg(REG_HI, 32'h0010_0000);
    write_reg(3'd7, 32'hFFFF_FFFF);  // no such register
    send_cmd(OP_STEP, 32'h0002_0000, 32'h0001_0000, 24'h01_0000);  // first step
    send_cmd(OP_STEP, 32'h0003_0000, 32'h0001_0000, 24'h01_0000);  // with derivative
    send_cmd(OP_STEP, 32'h0003_0000, 32'h0001_0000, 24'd0);        // zero time step
    send_cmd(OP_STEP, 32'h0001_0000, 32'h0004_0000, 24'd1);        // tiny step
    send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);  // clamp high
    send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);  // windup held
    send_cmd(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);  // clamp low
    send_cmd(OP_STEP, 32'h0000_0000, 32'h0000_0000, 24'h80_0000);
    send_cmd(OP_CLEAR, 32'h0, 32'h0, 24'h0);
    // reversed limits
    write_reg(REG_LO, 32'h0005_0000);
    write_reg(REG_HI, 32'hFFFB_0000);
    send_cmd(OP_STEP, 32'h0100_0000, 32'h0000_0000, 24'h10_0000);
    send_cmd(OP_STEP, 32'hFF00_0000, 32'h0000_0000, 24'h10_0000);
    send_cmd(OP_STEP, 32'h0000_1000, 32'h0000_0000, 24'h00_1000);
    // extreme gains
    write_reg(REG_KP, 32'h7FFF_FFFF);
    write_reg(REG_KI, 32'h8000_0000);
    write_reg(REG_KD, 32'h7FFF_FFFF);
    write_reg(REG_LO, 32'h8000_0000);
    write_reg(REG_HI, 32'h7FFF_FFFF);
    send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
    send_cmd(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
    send_cmd(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    write_reg(REG_KP, 32'h8000_0000);
    write_reg(REG_KD, 32'h8000_0000);
    send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'd2);
    pause_sender();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        pause_sender();
        random_gains();
      end
      send_random();
    end
    pause_sender();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_KP, 32'h0000_8000);
    write_reg(REG_KI, 32'h0000_4000);
    fork
      begin
        rsp_hold = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        rsp_hold = 1'b0;
      end
      repeat (12) send_random();
    join
    pause_sender();
    repeat (10) send_random();
    pause_sender();
  endtask

  initial begin
    rst_n = 1'b0;
    rsp_hold = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    cycle_cnt = 0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.operation = OP_STEP;
    req.setpoint = '0;
    req.measured = '0;
    req.time_step = '0;
    gain_p = '0;
    gain_i = '0;
    gain_d = '0;
    lim_lo = 32'h8000_0000;
    lim_hi = 32'h7FFF_FFFF;
    integ_acc = 0;
    prev_err = 0;
    primed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_phase(0, 0, 140);
    test_random_phase(64, 0, 140);
    test_random_phase(0, 64, 140);
    test_random_phase(25, 25, 140);
    test_backpressure();

    idle_pct = 0;
    stall_pct = 0;
    wait_drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS pid_conditional_integration");
    end else begin
      $display("FAIL pid_conditional_integration");
    end
    $finish;
  end

endmodule

// ----- pid_conditional_integration.f -----
+incdir+rtl
rtl/pci_pkg.sv
rtl/pci_if.sv
rtl/pid_conditional_integration.sv
tb/sv/tb_top.sv
